// ===== rtl/acmfl_pkg.sv =====
`default_nettype none

package acmfl_pkg;

  localparam int unsigned SampleWidth = 16;
  localparam int unsigned MagWidth    = 15;
  localparam int unsigned CountWidth  = 8;
  localparam int unsigned CoefWidth   = 12;
  localparam int unsigned ProdVbWidth = SampleWidth + CoefWidth + 1;
  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned CfgWidth    = 15;

  // all-pass coefficients, Q12
  localparam logic [CoefWidth-1:0] COEF_A_50 = 12'd3947;
  localparam logic [CoefWidth-1:0] COEF_B_50 = 12'd3798;
  localparam logic [CoefWidth-1:0] COEF_A_60 = 12'd3971;
  localparam logic [CoefWidth-1:0] COEF_B_60 = 12'd3846;

  localparam logic [MagWidth-1:0]   MAG_MAX         = 15'h7fff;
  localparam logic [MagWidth-1:0]   RESET_THRESHOLD = 15'd650;
  localparam logic [CountWidth-1:0] RESET_LIMIT     = 8'd13;

  localparam logic [CfgIdxWidth-1:0] CFG_LINE_60HZ   = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_THRESHOLD   = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CFG_LIMIT       = 2'd2;

  typedef struct packed {
    logic                  line_is_60hz;
    logic [MagWidth-1:0]   loss_threshold;
    logic [CountWidth-1:0] confirm_limit;
  } cfg_t;

  typedef struct packed {
    logic signed [SampleWidth-1:0] lag;
    logic signed [SampleWidth-1:0] v;
  } filt_beat_t;

  // |x| of a 16-bit two's complement value; -32768 gives 32768
  function automatic logic [SampleWidth-1:0] abs16(input logic signed [SampleWidth-1:0] x);
    logic [SampleWidth-1:0] r;
    r = x[SampleWidth-1] ? SampleWidth'(-x) : x;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ac_mains_fast_loss_detector.sv =====
`default_nettype none

// Fast mains-loss detector. Each input beat is one signed 16-bit phase-voltage
// sample; a first-order all-pass (50/60 Hz coefficients by register 0) forms a
// ~90 degree lagged copy, |v|+|lag| (saturated at 32767) is compared against
// loss_threshold, and a confirmation counter with limit confirm_limit sets and
// clears the loss flag. One result beat per input beat. Throughput is one beat
// per clock while the output is not stalled; an accepted beat passes through
// three registers (input register, all-pass feedback register, detector output
// register) before it is presented on the output. Write configuration only
// while no beats are in flight.

module ac_mains_fast_loss_detector
  import acmfl_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CfgIdxWidth-1:0] cfg_index,
  input  wire logic [CfgWidth-1:0]    cfg_data,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [15:0]            s_tdata,   // [15:0] voltage_sample
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [31:0]                 m_tdata    // [15:0] quadrature_sample,
                                                 // [30:16] magnitude_estimate,
                                                 // [31] voltage_lost
);

  cfg_t                   cfg;
  logic                   f_valid;
  logic                   f_ready;
  filt_beat_t             f_beat;
  logic [SampleWidth-1:0] quadrature_sample;
  logic [MagWidth-1:0]    magnitude_estimate;
  logic                   voltage_lost;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.line_is_60hz   <= 1'b0;
      cfg.loss_threshold <= RESET_THRESHOLD;
      cfg.confirm_limit  <= RESET_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LINE_60HZ: cfg.line_is_60hz   <= cfg_data[0];
        CFG_THRESHOLD: cfg.loss_threshold <= cfg_data[MagWidth-1:0];
        CFG_LIMIT:     cfg.confirm_limit  <= cfg_data[CountWidth-1:0];
        default: ;
      endcase
    end
  end

  acmfl_filter u_filter (
    .clk          (clk),
    .rst          (rst),
    .line_is_60hz (cfg.line_is_60hz),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .in_sample    (s_tdata),
    .out_valid    (f_valid),
    .out_ready    (f_ready),
    .out_beat     (f_beat)
  );

  acmfl_detect u_detect (
    .clk                (clk),
    .rst                (rst),
    .cfg                (cfg),
    .in_valid           (f_valid),
    .in_ready           (f_ready),
    .in_beat            (f_beat),
    .out_valid          (m_tvalid),
    .out_ready          (m_tready),
    .quadrature_sample  (quadrature_sample),
    .magnitude_estimate (magnitude_estimate),
    .voltage_lost       (voltage_lost)
  );

  assign m_tdata = {voltage_lost, magnitude_estimate, quadrature_sample};

endmodule

`default_nettype wire

// ===== rtl/acmfl_filter.sv =====
`default_nettype none

module acmfl_filter
  import acmfl_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          line_is_60hz,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [SampleWidth-1:0] in_sample,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output filt_beat_t                         out_beat
);

  logic                          smp_valid;
  logic signed [SampleWidth-1:0] smp_v;
  logic signed [ProdVbWidth-1:0] smp_vb;
  logic                          f_ready;

  logic signed [SampleWidth-1:0] lagged_value;
  logic signed [SampleWidth-1:0] previous_sample;

  logic [CoefWidth-1:0]          coef_a;
  logic [CoefWidth-1:0]          coef_b;
  logic signed [SampleWidth:0]   lag_sum;
  logic signed [29:0]            prod_a;
  logic signed [30:0]            t_full;
  logic signed [SampleWidth-1:0] lag_next;

  assign coef_a = line_is_60hz ? COEF_A_60 : COEF_A_50;
  assign coef_b = line_is_60hz ? COEF_B_60 : COEF_B_50;

  assign f_ready  = !out_valid || out_ready;
  assign in_ready = !smp_valid || f_ready;

  // input register; v*B is formed here so the feedback path holds one multiply
  always_ff @(posedge clk) begin
    if (rst) begin
      smp_valid <= 1'b0;
    end else if (in_ready) begin
      smp_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      smp_v  <= in_sample;
      smp_vb <= ProdVbWidth'(in_sample) * ProdVbWidth'($signed({1'b0, coef_b}));
    end
  end

  always_comb begin
    lag_sum  = {lagged_value[SampleWidth-1], lagged_value}
             + {previous_sample[SampleWidth-1], previous_sample};
    prod_a   = 30'(lag_sum) * 30'($signed({1'b0, coef_a}));
    t_full   = {prod_a[29], prod_a} - {{(31-ProdVbWidth){smp_vb[ProdVbWidth-1]}}, smp_vb};
    // floor(t / 4096), wrapped to 16 bits
    lag_next = t_full[27:12];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid       <= 1'b0;
      lagged_value    <= '0;
      previous_sample <= '0;
    end else begin
      if (f_ready) begin
        out_valid <= smp_valid;
      end
      if (f_ready && smp_valid) begin
        lagged_value    <= lag_next;
        previous_sample <= smp_v;
      end
    end
    if (f_ready && smp_valid) begin
      out_beat.lag <= lag_next;
      out_beat.v   <= smp_v;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/acmfl_detect.sv =====
`default_nettype none

module acmfl_detect
  import acmfl_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire cfg_t                cfg,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire filt_beat_t          in_beat,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [SampleWidth-1:0]   quadrature_sample,
  output logic [MagWidth-1:0]      magnitude_estimate,
  output logic                     voltage_lost
);

  logic [CountWidth-1:0]  confirm_counter;
  logic                   loss_flag;
  logic [CountWidth-1:0]  counter_next;
  logic                   flag_next;
  logic [SampleWidth:0]   mag_sum;
  logic [MagWidth-1:0]    mag;
  logic                   below;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    mag_sum = {1'b0, abs16(in_beat.v)} + {1'b0, abs16(in_beat.lag)};
    mag     = (mag_sum[SampleWidth] || mag_sum[SampleWidth-1]) ? MAG_MAX
                                                               : mag_sum[MagWidth-1:0];
    below   = mag < cfg.loss_threshold;

    counter_next = confirm_counter;
    flag_next    = loss_flag;
    if (below) begin
      if (confirm_counter < cfg.confirm_limit) begin
        counter_next = confirm_counter + 1'b1;
      end else begin
        flag_next = 1'b1;
      end
    end else begin
      if (confirm_counter != '0) begin
        counter_next = confirm_counter - 1'b1;
      end else begin
        flag_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid       <= 1'b0;
      confirm_counter <= '0;
      loss_flag       <= 1'b0;
    end else begin
      if (in_ready) begin
        out_valid <= in_valid;
      end
      if (in_ready && in_valid) begin
        confirm_counter <= counter_next;
        loss_flag       <= flag_next;
      end
    end
    if (in_ready && in_valid) begin
      quadrature_sample  <= in_beat.lag;
      magnitude_estimate <= mag;
      voltage_lost       <= flag_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/acmfl_checker.sv =====
`default_nettype none

module acmfl_checker
  import acmfl_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata
);

  logic [SampleWidth-1:0] quad_abs;
  logic [MagWidth-1:0]    mag_field;

  assign quad_abs  = abs16(m_tdata[15:0]);
  assign mag_field = m_tdata[30:16];

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output beat valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output beat changed");

  // with the output empty no stage can be blocked
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while output empty");

  a_mag_covers_quad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (mag_field == MAG_MAX) || ({1'b0, mag_field} >= quad_abs))
    else $error("magnitude below quadrature magnitude");

endmodule

bind ac_mains_fast_loss_detector acmfl_checker u_acmfl_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== bench/tb_ac_mains_fast_loss_detector.sv =====
`default_nettype none

module tb_ac_mains_fast_loss_detector;
  import acmfl_pkg::*;

  localparam int LATENCY        = 3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PRINT_LIMIT    = 100;
  localparam int PHASE_BEATS    = 244;

  // index 3 is not decoded by the block
  localparam logic [CfgIdxWidth-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic signed [15:0] quad;
    logic [14:0]        mag;
    logic               lost;
  } det_out_t;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   cfg_we    = 1'b0;
  logic [CfgIdxWidth-1:0] cfg_index = '0;
  logic [CfgWidth-1:0]    cfg_data  = '0;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [15:0]            s_tdata   = '0;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [31:0]            m_tdata;

  // detector state as the block should hold it
  logic                   mode_60hz   = 1'b0;
  logic [14:0]            loss_thr    = RESET_THRESHOLD;
  logic [7:0]             confirm_lim = RESET_LIMIT;
  logic signed [15:0]     lag_state   = '0;
  logic signed [15:0]     prev_state  = '0;
  logic [7:0]             confirm_cnt = '0;
  logic                   lost_state  = 1'b0;

  det_out_t predicted_outputs[$];

  int  errors      = 0;
  int  stall_left  = 0;
  bit  send_gaps   = 1'b1;
  bit  recv_stalls = 1'b1;

  ac_mains_fast_loss_detector i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always #1 clk = ~clk;

  function automatic int draw_wait(input bit enabled);
    return enabled ? int'($urandom_range(0, 15)) : 0;
  endfunction

  // all-pass step, saturated magnitude and loss confirmation
  function automatic det_out_t filter_and_detect(input logic signed [15:0] v);
    longint             coef_a;
    longint             coef_b;
    longint             acc;
    longint             shifted;
    logic signed [15:0] lag_new;
    int                 abs_v;
    int                 abs_l;
    int                 sum;
    det_out_t           r;
    coef_a  = mode_60hz ? longint'(COEF_A_60) : longint'(COEF_A_50);
    coef_b  = mode_60hz ? longint'(COEF_B_60) : longint'(COEF_B_50);
    acc     = (longint'(lag_state) + longint'(prev_state)) * coef_a - longint'(v) * coef_b;
    shifted = acc >>> 12;
    lag_new = shifted[15:0];
    abs_v   = (v < 0) ? -int'(v) : int'(v);
    abs_l   = (lag_new < 0) ? -int'(lag_new) : int'(lag_new);
    sum     = abs_v + abs_l;
    if (sum > 32767) sum = 32767;
    if (sum < int'(loss_thr)) begin
      if (confirm_cnt < confirm_lim) confirm_cnt = confirm_cnt + 8'd1;
      else lost_state = 1'b1;
    end else begin
      if (confirm_cnt > 0) confirm_cnt = confirm_cnt - 8'd1;
      else lost_state = 1'b0;
    end
    lag_state  = lag_new;
    prev_state = v;
    r.quad = lag_new;
    r.mag  = 15'(sum);
    r.lost = lost_state;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= PRINT_LIMIT) $display("mismatch: %s", what);
  endtask

  task automatic send_sample(input logic signed [15:0] v);
    int gap;
    gap = draw_wait(send_gaps);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted_outputs.push_back(filter_and_detect(v));
  endtask

  task automatic wait_results_done();
    s_tvalid <= 1'b0;
    while (predicted_outputs.size() != 0) @(posedge clk);
    repeat (LATENCY * 4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx, input logic [CfgWidth-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_LINE_60HZ: mode_60hz   = val[0];
      CFG_THRESHOLD: loss_thr    = val;
      CFG_LIMIT:     confirm_lim = val[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // result side: check each beat, then draw the stall for the next one
  always @(posedge clk) begin
    det_out_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (predicted_outputs.size() == 0) begin
        report_mismatch($sformatf("result beat %h with nothing pending", m_tdata));
      end else begin
        want = predicted_outputs.pop_front();
        if (m_tdata[15:0] !== want.quad)
          report_mismatch($sformatf("quadrature %h, want %h", m_tdata[15:0], want.quad));
        if (m_tdata[30:16] !== want.mag)
          report_mismatch($sformatf("magnitude %0d, want %0d", m_tdata[30:16], want.mag));
        if (m_tdata[31] !== want.lost)
          report_mismatch($sformatf("loss flag %b, want %b", m_tdata[31], want.lost));
      end
      stall_left = draw_wait(recv_stalls);
    end
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else begin
      m_tready <= 1'b1;
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("[ac_mains_fast_loss_detector] ERROR");
    $finish;
  end

  // counter up, limit dropped under the counter, then count down and clear
  task automatic test_loss_confirm();
    repeat (3) send_sample(16'sd0);
    wait_results_done();
    write_reg(CFG_LIMIT, 15'd1);
    send_sample(16'sd0);
    repeat (4) send_sample(16'sd20000);
  endtask

  // full-scale steps: magnitude saturation and lag wrap
  task automatic test_filter_extremes();
    wait_results_done();
    write_reg(CFG_LIMIT, 15'(RESET_LIMIT));
    repeat (4) send_sample(16'sd32767);
    send_sample(-16'sd32768);
    send_sample(16'sd32767);
    send_sample(-16'sd32768);
    send_sample(-16'sd1);
    send_sample(16'sd1);
    send_sample(16'sh5555);
  endtask

  task automatic test_60hz_mode();
    wait_results_done();
    write_reg(CFG_LINE_60HZ, 15'd1);
    repeat (2) send_sample(16'sd32767);
    send_sample(-16'sd32768);
    send_sample(16'sd0);
    send_sample(-16'sd32768);
  endtask

  task automatic test_unused_index();
    wait_results_done();
    write_reg(CFG_UNUSED, 15'h7fff);
    send_sample(16'sd100);
    send_sample(-16'sd100);
  endtask

  // one stretch of mains-like wave, sag or noise
  task automatic run_segment(inout int sent);
    int kind;
    int len;
    int amp;
    int period;
    int ph;
    int v_int;
    kind        = $urandom_range(0, 9);
    send_gaps   = ($urandom_range(0, 3) != 0);
    recv_stalls = ($urandom_range(0, 3) != 0);
    period      = $urandom_range(4, 80);
    if (kind <= 5) begin
      len = $urandom_range(10, 80);
      amp = $urandom_range(1000, 32767);
    end else if (kind <= 8) begin
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(200, 300) : $urandom_range(5, 40);
      amp = $urandom_range(0, 500);
    end else begin
      len = $urandom_range(5, 30);
      amp = 0;
    end
    if (len > PHASE_BEATS - sent) len = PHASE_BEATS - sent;
    for (int k = 0; k < len; k++) begin
      if (kind == 9) begin
        v_int = int'($urandom_range(0, 65535)) - 32768;
      end else begin
        ph = k % period;
        if (2 * ph < period) v_int = -amp + (4 * amp * ph) / period;
        else v_int = 3 * amp - (4 * amp * ph) / period;
        v_int = v_int + int'($urandom_range(0, 16)) - 8;
      end
      if (v_int > 32767) v_int = 32767;
      if (v_int < -32768) v_int = -32768;
      send_sample(16'(v_int));
      sent++;
      if ($urandom_range(0, 199) == 0) wait_results_done();
    end
  endtask

  task automatic test_random_mains();
    bit hz_list[8]  = '{0, 1, 0, 1, 0, 1, 0, 1};
    int thr_list[8] = '{650, 650, 0, 32767, 2000, 1500, 32767, 0};
    int lim_list[8] = '{13, 13, 0, 255, 0, 255, 0, 255};
    int thr;
    int lim;
    int sent;
    for (int p = 0; p < 8; p++) begin
      thr = thr_list[p];
      lim = lim_list[p];
      if (p >= 6) begin
        thr = $urandom_range(300, 3000);
        lim = $urandom_range(0, 40);
      end
      wait_results_done();
      write_reg(CFG_LINE_60HZ, 15'(hz_list[p]));
      write_reg(CFG_THRESHOLD, 15'(thr));
      write_reg(CFG_LIMIT, 15'(lim));
      sent = 0;
      while (sent < PHASE_BEATS) run_segment(sent);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_loss_confirm();
    test_filter_extremes();
    test_60hz_mode();
    test_unused_index();
    test_random_mains();
    wait_results_done();
    if (errors == 0) begin
      $display("[ac_mains_fast_loss_detector] OK");
    end else begin
      $display("[ac_mains_fast_loss_detector] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
